// ----- hw/rtl/lpht_pkg.sv -----
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared constants, types and helpers for the linear probe hash table unit.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BYTES   = 8;

  localparam int KEY_W      = 64;
  localparam int VAL_W      = 32;
  localparam int STATUS_W   = 3;
  localparam int SLOT_OUT_W = 4;
  localparam int SLOT_W     = $clog2(TABLE_DEPTH);
  localparam int BCNT_W     = $clog2(KEY_BYTES + 1);
  localparam int BYTE_IDX_W = 3;
  localparam int RAM_W      = KEY_W + VAL_W;

  localparam logic [KEY_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
  // FNV prime is 2^40 + 0x1B3
  localparam int               FNV_SHIFT = 40;
  localparam logic [8:0]       FNV_LO    = 9'h1B3;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  localparam logic OP_PUT = 1'b0;
  localparam logic OP_GET = 1'b1;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic set_home;
    logic advance;
    logic finish;
  } lpht_cmd_t;

  typedef struct packed {
    logic hash_done;
    logic hit_empty;
    logic key_match;
    logic last_probe;
    logic out_free;
  } lpht_sts_t;

  // cut the key at its first zero byte and at KEY_BYTES
  function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] k;
    logic             alive;
    k     = '0;
    alive = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (raw[8*i +: 8] == 8'h00 || i >= KEY_BYTES) begin
        alive = 1'b0;
      end
      if (alive) begin
        k[8*i +: 8] = raw[8*i +: 8];
      end
    end
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] fnv_step(input logic [KEY_W-1:0] h,
                                                input logic [7:0]       b);
    logic [KEY_W-1:0] x;
    x = h ^ {{(KEY_W-8){1'b0}}, b};
    return (x << FNV_SHIFT) + x * {{(KEY_W-9){1'b0}}, FNV_LO};
  endfunction

endpackage

// ----- hw/rtl/lpht_if.sv -----
// ----------------------------------------------------------------------------
// lpht_if
// Request and response channels of the linear probe hash table unit.
// ----------------------------------------------------------------------------
interface lpht_req_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [lpht_pkg::KEY_W-1:0] key;
  logic [lpht_pkg::VAL_W-1:0] value;

  modport source (output valid, operation, key, value, input ready);
  modport sink   (input valid, operation, key, value, output ready);
endinterface

interface lpht_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [lpht_pkg::STATUS_W-1:0]   status;
  logic [lpht_pkg::VAL_W-1:0]      result_value;
  logic [lpht_pkg::SLOT_OUT_W-1:0] slot;

  modport source (output valid, status, result_value, slot, input ready);
  modport sink   (input valid, status, result_value, slot, output ready);
endinterface

// ----- hw/rtl/linear_probe_hash_table_unit.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Open-addressing key/value store, FNV-1a 64 hash, linear probing.
// ----------------------------------------------------------------------------
// req_i carries one request: operation (0 put, 1 get), key, value. It is taken
// when valid and ready are both high; ready is high only while the unit idles.
// rsp_o returns one response per request: status, result_value, slot.
// A request runs in steps: the FNV hash unit takes its key bytes before the
// first zero byte, one byte a cycle; the home slot is formed; the table read
// is primed; then one table slot is probed per cycle until the request
// settles and its response is loaded. The next request can be taken in the
// cycle after that. Throughput is set by the byte-serial hash and the
// single table read port.
// The response sits in an output register; a waiting response does not block
// the next request, which stalls only at its final probe until the register
// is free. Reset empties the table at once (per-slot valid flops) and drops
// any pending response.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit (
  input logic       clk_i,
  input logic       rst_ni,
  lpht_req_if.sink  req_i,
  lpht_rsp_if.source rsp_o
);
  import lpht_pkg::*;

  lpht_cmd_t cmd;
  lpht_sts_t sts;

  lpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lpht_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (req_i.operation),
    .key_i          (req_i.key),
    .value_i        (req_i.value),
    .out_ready_i    (rsp_o.ready),
    .out_valid_o    (rsp_o.valid),
    .status_o       (rsp_o.status),
    .result_value_o (rsp_o.result_value),
    .slot_o         (rsp_o.slot)
  );

  a_busy_after_accept : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready
  ) else $error("request taken while a request is in flight");

  a_finish_needs_room : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!rsp_o.valid || rsp_o.ready)
  ) else $error("response overwrote a pending response");

  a_miss_is_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == ST_NOT_FOUND || rsp_o.status == ST_FULL))
      |-> (rsp_o.result_value == '0 && rsp_o.slot == '0)
  ) else $error("miss response carries nonzero value or slot");

endmodule

// ----- hw/rtl/lpht_ram.sv -----
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/lpht_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpht_ctrl
// Sequencer: accept, hash bytes, prime the table read, probe, finish.
// ----------------------------------------------------------------------------
module lpht_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lpht_pkg::lpht_sts_t sts_i,
  output lpht_pkg::lpht_cmd_t cmd_o
);
  import lpht_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_HASH  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_PROBE = 2'd3;

  logic [1:0] state_q, state_d;
  logic       settled;

  assign settled = sts_i.hit_empty || sts_i.key_match || sts_i.last_probe;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_HASH;
        end
      end
      S_HASH: begin
        if (sts_i.hash_done) begin
          cmd_o.set_home = 1'b1;
          state_d        = S_READ;
        end else begin
          cmd_o.hash_step = 1'b1;
        end
      end
      S_READ: begin
        state_d = S_PROBE;
      end
      S_PROBE: begin
        if (settled) begin
          if (sts_i.out_free) begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/lpht_dp.sv -----
// ----------------------------------------------------------------------------
// lpht_dp
// Datapath: key register, FNV-1a hash unit, slot table, probe index, result.
// ----------------------------------------------------------------------------
module lpht_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lpht_pkg::lpht_cmd_t             cmd_i,
  output lpht_pkg::lpht_sts_t             sts_o,
  input  logic                            op_i,
  input  logic [lpht_pkg::KEY_W-1:0]      key_i,
  input  logic [lpht_pkg::VAL_W-1:0]      value_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [lpht_pkg::STATUS_W-1:0]   status_o,
  output logic [lpht_pkg::VAL_W-1:0]      result_value_o,
  output logic [lpht_pkg::SLOT_OUT_W-1:0] slot_o
);
  import lpht_pkg::*;

  logic                  op_q;
  logic [KEY_W-1:0]      key_q;
  logic [VAL_W-1:0]      val_q;
  logic [KEY_W-1:0]      hash_q, hash_d;
  logic [BCNT_W-1:0]     bcnt_q, bcnt_d;
  logic [SLOT_W-1:0]     idx_q, idx_d, idx_next;
  logic [SLOT_W-1:0]     pcnt_q, pcnt_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic                  out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [VAL_W-1:0]      rval_q, rval_d;
  logic [SLOT_OUT_W-1:0] slot_q, slot_d;

  logic [7:0]        cur_byte;
  logic              ram_we;
  logic [SLOT_W-1:0] raddr;
  logic [RAM_W-1:0]  rdata;
  logic              is_get;

  assign is_get   = (op_q == OP_GET);
  assign cur_byte = key_q[8*bcnt_q[BYTE_IDX_W-1:0] +: 8];
  assign idx_next = (idx_q == SLOT_W'(TABLE_DEPTH - 1)) ? '0 : idx_q + 1'b1;
  assign raddr    = cmd_i.advance ? idx_next : idx_q;

  assign sts_o.hash_done  = (bcnt_q == BCNT_W'(KEY_BYTES)) || (cur_byte == 8'h00);
  assign sts_o.hit_empty  = !valid_q[idx_q];
  assign sts_o.key_match  = (rdata[RAM_W-1:VAL_W] == key_q);
  assign sts_o.last_probe = (pcnt_q == SLOT_W'(TABLE_DEPTH - 1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // table write on insert or update
  assign ram_we = cmd_i.finish && !is_get && (sts_o.hit_empty || sts_o.key_match);

  lpht_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i ({key_q, val_q}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    hash_d = hash_q;
    bcnt_d = bcnt_q;
    idx_d  = idx_q;
    pcnt_d = pcnt_q;
    if (cmd_i.load) begin
      hash_d = FNV_BASIS;
      bcnt_d = '0;
      pcnt_d = '0;
    end
    if (cmd_i.hash_step) begin
      hash_d = fnv_step(hash_q, cur_byte);
      bcnt_d = bcnt_q + 1'b1;
    end
    if (cmd_i.set_home) begin
      idx_d = SLOT_W'(hash_q & KEY_W'(TABLE_DEPTH - 1));
    end
    if (cmd_i.advance) begin
      idx_d  = idx_next;
      pcnt_d = pcnt_q + 1'b1;
    end
  end

  always_comb begin
    valid_d     = valid_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    rval_d      = rval_q;
    slot_d      = slot_q;
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
      rval_d      = '0;
      slot_d      = '0;
      if (sts_o.hit_empty) begin
        if (is_get) begin
          status_d = ST_NOT_FOUND;
        end else begin
          status_d       = ST_INSERTED;
          rval_d         = val_q;
          slot_d         = SLOT_OUT_W'(idx_q);
          valid_d[idx_q] = 1'b1;
        end
      end else if (sts_o.key_match) begin
        slot_d = SLOT_OUT_W'(idx_q);
        if (is_get) begin
          status_d = ST_FOUND;
          rval_d   = rdata[VAL_W-1:0];
        end else begin
          status_d = ST_UPDATED;
          rval_d   = val_q;
        end
      end else begin
        status_d = is_get ? ST_NOT_FOUND : ST_FULL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      key_q <= norm_key(key_i);
      val_q <= value_i;
    end
    hash_q   <= hash_d;
    bcnt_q   <= bcnt_d;
    idx_q    <= idx_d;
    pcnt_q   <= pcnt_d;
    status_q <= status_d;
    rval_q   <= rval_d;
    slot_q   <= slot_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign result_value_o = rval_q;
  assign slot_o         = slot_q;

endmodule

// ----- bench/linear_probe_hash_table_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit_test
// Drives puts and gets into the hash table unit, mirrors the FNV-1a hashing
// and linear probing in a local table model, and checks every response
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit_test;
  import lpht_pkg::*;

  localparam int IDLE_PCT   = 36;
  localparam int HOLD_LEN   = 400;
  localparam int STALL_MAX  = 2000;
  localparam int RAND_ITEMS = 600;

  typedef struct {
    logic             op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    bit               drain;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0]   status;
    logic [VAL_W-1:0]      value;
    logic [SLOT_OUT_W-1:0] slot;
  } lookup_t;

  logic clk_i;
  logic rst_ni;

  lpht_req_if req_if ();
  lpht_rsp_if rsp_if ();

  linear_probe_hash_table_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  request_t         pending_q[$];
  lookup_t          lookup_q[$];
  int               accepted_cnt;
  int               err_cnt;
  int               hold_cnt;
  bit               hold_done;
  int               stall_cnt;

  bit               tbl_valid[TABLE_DEPTH];
  logic [KEY_W-1:0] tbl_key[TABLE_DEPTH];
  logic [VAL_W-1:0] tbl_value[TABLE_DEPTH];

  always #5 clk_i = ~clk_i;

  function automatic logic [KEY_W-1:0] trim_key(logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int i = 0; i < 8; i++) begin
      if (i >= KEY_BYTES || raw[8*i +: 8] == 8'h00) break;
      k[8*i +: 8] = raw[8*i +: 8];
    end
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] fnv1a_hash(logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] h;
    h = 64'd14695981039346656037;
    for (int i = 0; i < 8; i++) begin
      if (k[8*i +: 8] == 8'h00) break;
      h = (h ^ {56'd0, k[8*i +: 8]}) * 64'd1099511628211;
    end
    return h;
  endfunction

  // Probe the local table and apply a put, as the unit does.
  function automatic lookup_t probe_table(logic op, logic [KEY_W-1:0] raw,
                                          logic [VAL_W-1:0] val);
    lookup_t          res;
    logic [KEY_W-1:0] k;
    int               idx;
    k   = trim_key(raw);
    idx = int'(fnv1a_hash(k) & (TABLE_DEPTH - 1)) % TABLE_DEPTH;
    res = '{(op == OP_GET) ? ST_NOT_FOUND : ST_FULL, '0, '0};
    for (int n = 0; n < TABLE_DEPTH; n++) begin
      if (!tbl_valid[idx]) begin
        if (op == OP_PUT) begin
          tbl_valid[idx] = 1'b1;
          tbl_key[idx]   = k;
          tbl_value[idx] = val;
          res = '{ST_INSERTED, val, SLOT_OUT_W'(idx)};
        end
        return res;
      end
      if (tbl_key[idx] == k) begin
        if (op == OP_GET) begin
          res = '{ST_FOUND, tbl_value[idx], SLOT_OUT_W'(idx)};
        end else begin
          tbl_value[idx] = val;
          res = '{ST_UPDATED, val, SLOT_OUT_W'(idx)};
        end
        return res;
      end
      idx = (idx + 1) % TABLE_DEPTH;
    end
    return res;
  endfunction

  function automatic void add_request(logic op, logic [KEY_W-1:0] key,
                                      logic [VAL_W-1:0] value, bit drain);
    request_t r;
    r = '{op, key, value, drain};
    pending_q.push_back(r);
  endfunction

  function automatic bit quiet_window();
    return accepted_cnt >= 300 && accepted_cnt < 400;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    request_t nxt;
    bit       offer;
    if (!rst_ni) begin
      req_if.valid     <= 1'b0;
      req_if.operation <= OP_PUT;
      req_if.key       <= '0;
      req_if.value     <= '0;
    end else begin
      offer = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        lookup_q.push_back(probe_table(req_if.operation, req_if.key, req_if.value));
        accepted_cnt++;
        offer = 1'b0;
      end
      if (!offer && pending_q.size() > 0 &&
          !(pending_q[0].drain && lookup_q.size() > 0) &&
          (quiet_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = pending_q.pop_front();
        req_if.operation <= nxt.op;
        req_if.key       <= nxt.key;
        req_if.value     <= nxt.value;
        offer = 1'b1;
      end
      req_if.valid <= offer;
    end
  end

  // response monitor
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      hold_cnt  = 0;
      hold_done = 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (lookup_q.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want = lookup_q.pop_front();
          if (rsp_if.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      rsp_if.status, want.status));
          if (rsp_if.result_value !== want.value)
            report_mismatch($sformatf("result_value %h, expected %h",
                                      rsp_if.result_value, want.value));
          if (rsp_if.slot !== want.slot)
            report_mismatch($sformatf("slot %0d, expected %0d",
                                      rsp_if.slot, want.slot));
        end
      end
      if (!hold_done && accepted_cnt >= 120) begin
        hold_done = 1'b1;
        hold_cnt  = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= quiet_window() || $urandom_range(0, 99) >= IDLE_PCT;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        stall_cnt = 0;
      end else begin
        stall_cnt++;
        if (stall_cnt >= STALL_MAX) begin
          $display("linear_probe_hash_table_unit test failed");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [KEY_W-1:0] stored_keys[$];
    logic [KEY_W-1:0] absent_keys[$];
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] tail;
    int               len;
    int               pick;

    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.operation = OP_PUT;
    req_if.key       = '0;
    req_if.value     = '0;
    rsp_if.ready     = 1'b0;
    accepted_cnt     = 0;
    err_cnt          = 0;
    stall_cnt        = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_value[i] = '0;
    end

    // empty table, empty key, extremes, cut keys
    add_request(OP_GET, 64'h0, $urandom, 1'b0);
    add_request(OP_PUT, 64'h0, 32'h0, 1'b0);
    add_request(OP_PUT, '1, '1, 1'b0);
    add_request(OP_PUT, 64'hAB00_1234_5600_0041, 32'h1234_5678, 1'b0);
    add_request(OP_PUT, 64'h41, 32'h8765_4321, 1'b0);
    add_request(OP_GET, 64'hFFFF_FFFF_0000_0041, $urandom, 1'b0);
    add_request(OP_GET, 64'h1234_5678_0000_0000, $urandom, 1'b0);
    add_request(OP_GET, 64'h4242, $urandom, 1'b0);
    stored_keys = '{64'h0, '1, 64'h41};

    // fill the remaining slots with keys of every length
    for (int i = 0; i < TABLE_DEPTH - 3; i++) begin
      k = '0;
      k[7:0] = 8'(8'h61 + i);
      for (int b = 1; b <= i % 8; b++) k[8*b +: 8] = 8'($urandom_range(1, 255));
      stored_keys.push_back(k);
      add_request(OP_PUT, k, $urandom, 1'b0);
    end

    // full table: put refused, get misses after a whole sweep
    add_request(OP_PUT, 64'h7A, $urandom, 1'b0);
    add_request(OP_GET, 64'h7A, $urandom, 1'b0);
    add_request(OP_GET, stored_keys[stored_keys.size()-1], $urandom, 1'b0);

    absent_keys = '{64'h7A, 64'h4242};
    for (int i = 0; i < 4; i++) absent_keys.push_back({$urandom, $urandom});

    for (int i = 0; i < RAND_ITEMS; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        k   = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        len = 0;
        while (len < 8 && k[8*len +: 8] != 8'h00) len++;
        // junk above the terminating zero byte
        if (len < 7) begin
          tail = {$urandom, $urandom};
          k    = k | (tail << (8 * (len + 1)));
        end
      end else if (pick < 8) begin
        k = absent_keys[$urandom_range(0, absent_keys.size() - 1)];
      end else begin
        k = {$urandom, $urandom};
      end
      add_request(1'($urandom_range(0, 1)), k, $urandom, i == 0 || i == 400);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() > 0 || req_if.valid) @(posedge clk_i);
    while (lookup_q.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("linear_probe_hash_table_unit test passed");
    end else begin
      $display("linear_probe_hash_table_unit test failed");
    end
    $finish;
  end

endmodule
